@@ rtl/median_threshold_peak_picker_unit_macros.svh @@
// Assertion macros for the peak picker checker.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef MEDIAN_THRESHOLD_PEAK_PICKER_UNIT_MACROS_SVH
`define MEDIAN_THRESHOLD_PEAK_PICKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MTPP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("peak picker assertion failed");

// Next-cycle implication, disabled during reset
`define MTPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("peak picker assertion failed");

`endif

@@ rtl/mtpp_pkg.sv @@
// Package for the median threshold peak picker: sizes, types and the judging functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtpp_pkg;

  localparam int MAX_FRAMES     = 65536;
  localparam int SAMPLE_BITS    = 16;
  localparam int HOLDOFF_FRAMES = 3;

  localparam int IN_BITS    = 16;
  localparam int INDEX_BITS = 16;
  localparam int OFFSET_BITS = 16;
  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 16'd13107;

  localparam int WIN   = 5;
  localparam int FC_W  = $clog2(MAX_FRAMES + 1);
  localparam int HO_W  = (HOLDOFF_FRAMES > 0) ? $clog2(HOLDOFF_FRAMES + 1) : 1;
  localparam int THR_W = ((SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS) + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FP_W       = $clog2(FIFO_DEPTH);
  localparam int FC_CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef logic [SAMPLE_BITS-1:0]          sample_t;
  typedef logic [WIN-1:0][SAMPLE_BITS-1:0] win_t;
  typedef logic [FC_W-1:0]                 frame_cnt_t;
  typedef logic [HO_W-1:0]                 hold_t;
  typedef logic [INDEX_BITS-1:0]           index_t;
  typedef logic [OFFSET_BITS-1:0]          offset_t;
  typedef logic [THR_W-1:0]                thr_t;

  typedef struct packed {
    index_t peak_index;
    logic   last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic  peak;
    hold_t hold;
  } judge_t;

  function automatic sample_t med3(sample_t x, sample_t y, sample_t z);
    sample_t lo;
    sample_t hi;
    sample_t m;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    m  = (hi < z) ? hi : z;
    return (lo > m) ? lo : m;
  endfunction

  function automatic sample_t med5(win_t w);
    sample_t f;
    sample_t g;
    sample_t min01;
    sample_t min23;
    sample_t max01;
    sample_t max23;
    min01 = (w[0] < w[1]) ? w[0] : w[1];
    max01 = (w[0] < w[1]) ? w[1] : w[0];
    min23 = (w[2] < w[3]) ? w[2] : w[3];
    max23 = (w[2] < w[3]) ? w[3] : w[2];
    f = (min01 > min23) ? min01 : min23;
    g = (max01 < max23) ? max01 : max23;
    return med3(w[4], f, g);
  endfunction

  function automatic judge_t judge(win_t w, hold_t hold, offset_t off);
    judge_t j;
    thr_t   thr;
    thr = thr_t'(med5(w)) + thr_t'(off);
    j.peak = 1'b0;
    j.hold = hold;
    if (hold != '0) begin
      j.hold = hold - 1'b1;
    end else if ((w[1] < w[2]) && (w[3] < w[2]) && (thr_t'(w[2]) > thr)) begin
      j.peak = 1'b1;
      j.hold = hold_t'(HOLDOFF_FRAMES);
    end
    return j;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mtpp_if.sv @@
// Channel interfaces for the peak picker: sample input, peak result and offset write.
// Depends on mtpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mtpp_in_if;
  import mtpp_pkg::*;
  logic                valid;
  logic                ready;
  logic [IN_BITS-1:0]  novelty_sample;
  logic                end_of_sequence;
  modport source (output valid, output novelty_sample, output end_of_sequence, input ready);
  modport sink (input valid, input novelty_sample, input end_of_sequence, output ready);
endinterface

interface mtpp_out_if;
  import mtpp_pkg::*;
  logic   valid;
  logic   ready;
  index_t peak_index;
  logic   last_of_run;
  modport source (output valid, output peak_index, output last_of_run, input ready);
  modport sink (input valid, input peak_index, input last_of_run, output ready);
endinterface

interface mtpp_cfg_if;
  import mtpp_pkg::*;
  logic    valid;
  logic    ready;
  offset_t threshold_offset;
  modport source (output valid, output threshold_offset, input ready);
  modport sink (input valid, input threshold_offset, output ready);
endinterface

`default_nettype wire

@@ rtl/mtpp_frame_stage.sv @@
// Input register, sample window, frame counter, hold-off and peak judgement.
// Depends on mtpp_pkg and mtpp_if.
`timescale 1ns / 1ps
`default_nettype none

module mtpp_frame_stage (
  input  wire logic         clk,
  input  wire logic         rst_n,
  mtpp_in_if.sink           in_if,
  mtpp_cfg_if.sink          cfg_if,
  input  wire logic         room,
  output mtpp_pkg::push_t   push
);
  import mtpp_pkg::*;

  logic       a_valid_r;
  sample_t    a_sample_r;
  logic       a_eos_r;
  offset_t    off_r;
  win_t       win_r, win_nxt;
  frame_cnt_t fc_r, fc_nxt;
  hold_t      hold_r, hold_nxt;

  logic       adv;
  logic       load;
  logic       take;
  win_t       w1, w2;
  frame_cnt_t fc1;
  logic       j1_en, j2_en;
  judge_t     j1, j2;
  hold_t      hold1;
  logic       p1, p2;
  index_t     idx1, idx2;

  assign adv          = a_valid_r && room;
  assign in_if.ready  = !a_valid_r || adv;
  assign load         = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_comb begin
    take  = (fc_r < frame_cnt_t'(MAX_FRAMES));
    w1    = take ? {a_sample_r, win_r[WIN-1:1]} : win_r;
    fc1   = take ? fc_r + 1'b1 : fc_r;
    j1_en = take && (fc1 >= frame_cnt_t'(4));
    j1    = judge(w1, hold_r, off_r);
    hold1 = j1_en ? j1.hold : hold_r;
    w2    = {sample_t'(0), w1[WIN-1:1]};
    j2_en = a_eos_r && (fc1 >= frame_cnt_t'(3));
    j2    = judge(w2, hold1, off_r);
    p1    = j1_en && j1.peak;
    p2    = j2_en && j2.peak;
    idx1  = index_t'(fc1 - frame_cnt_t'(3));
    idx2  = index_t'(fc1 - frame_cnt_t'(2));
  end

  always_comb begin
    push.r0 = '{peak_index: p1 ? idx1 : idx2, last_of_run: !(p1 && p2)};
    push.r1 = '{peak_index: idx2, last_of_run: 1'b1};
    push.n  = '0;
    if (adv) begin
      push.n = {1'b0, p1} + {1'b0, p2};
    end
  end

  always_comb begin
    win_nxt  = win_r;
    fc_nxt   = fc_r;
    hold_nxt = hold_r;
    if (adv) begin
      if (a_eos_r) begin
        win_nxt  = '0;
        fc_nxt   = '0;
        hold_nxt = '0;
      end else begin
        win_nxt  = w1;
        fc_nxt   = fc1;
        hold_nxt = hold1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      off_r     <= OFFSET_RESET;
      win_r     <= '0;
      fc_r      <= '0;
      hold_r    <= '0;
    end else begin
      if (load) begin
        a_valid_r <= 1'b1;
      end else if (adv) begin
        a_valid_r <= 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        off_r <= cfg_if.threshold_offset;
      end
      win_r  <= win_nxt;
      fc_r   <= fc_nxt;
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_sample_r <= sample_t'(in_if.novelty_sample);
      a_eos_r    <= in_if.end_of_sequence;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mtpp_result_fifo.sv @@
// Small result queue taking up to two peaks per cycle and giving one per transfer.
// Depends on mtpp_pkg and mtpp_if.
`timescale 1ns / 1ps
`default_nettype none

module mtpp_result_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mtpp_pkg::push_t push,
  output logic                room,
  mtpp_out_if.source          out_if
);
  import mtpp_pkg::*;

  res_t                mem_r [FIFO_DEPTH];
  logic [FP_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [FP_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [FC_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FP_W-1:0]     wr_ptr_inc;
  logic                pop;

  assign pop        = out_if.valid && out_if.ready;
  assign wr_ptr_inc = wr_ptr_r + 1'b1;
  assign room       = (cnt_r <= FC_CNT_W'(FIFO_DEPTH - 2));

  assign out_if.valid       = (cnt_r != '0);
  assign out_if.peak_index  = mem_r[rd_ptr_r].peak_index;
  assign out_if.last_of_run = mem_r[rd_ptr_r].last_of_run;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FP_W'(push.n);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + FC_CNT_W'(push.n) - FC_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != '0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_inc] <= push.r1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/median_threshold_peak_picker_unit.sv @@
// Median threshold peak picker, top level.
// A peak is valid on out_if once the sample that decides it has passed the input register and entered the queue.
// One sample per cycle while the queue has room; a sample that yields two peaks takes two output transfers.
// Three or more held results in the four-entry queue hold the input register and stall in_if.
// Reset (rst_n low, synchronous): window, frame and hold-off counters clear, queue empties,
// threshold_offset returns to 13107.
`timescale 1ns / 1ps
`default_nettype none

module median_threshold_peak_picker_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  mtpp_in_if.sink   in_if,
  mtpp_out_if.source out_if,
  mtpp_cfg_if.sink  cfg_if
);
  import mtpp_pkg::*;

  push_t push;
  logic  room;

  mtpp_frame_stage u_frame_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .room   (room),
    .push   (push)
  );

  mtpp_result_fifo u_result_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_if (out_if)
  );

endmodule

`default_nettype wire

@@ rtl/mtpp_checker.sv @@
// Port-level checks for the peak picker, bound to the top level.
// Depends on median_threshold_peak_picker_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "median_threshold_peak_picker_unit_macros.svh"

module mtpp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  `MTPP_ASSERT_SAME(a_idle_accepts, !out_valid, in_ready)
  `MTPP_ASSERT_SAME(a_result_has_source, $rose(out_valid), $past(in_valid && in_ready, 2))
  `MTPP_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)

endmodule

bind median_threshold_peak_picker_unit mtpp_checker u_mtpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready)
);

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for median_threshold_peak_picker_unit: streams novelty sequences,
// predicts peak indices from its own window model and checks every peak transfer.
// Depends on mtpp_pkg and the channel interfaces in mtpp_if.sv.
`timescale 1ns / 1ps

module testbench;
  import mtpp_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int IDLE_PCT      = 27;
  localparam int CALM_FROM     = 1000;
  localparam int CALM_TO       = 1400;
  localparam int STALL_FIRST   = 400;
  localparam int STALL_SECOND  = 30000;
  localparam int STALL_CYCLES  = 300;
  localparam int PHASE_ITEMS   = 250;

  typedef enum logic {FEED_SAMPLE, FEED_OFFSET} feed_kind_t;
  typedef enum int {SHAPE_NOISE, SHAPE_SPIKY, SHAPE_STEPS} shape_t;

  typedef struct {
    feed_kind_t kind;
    sample_t    sample;
    logic       eos;
    offset_t    offset;
  } feed_t;

  logic clk;
  logic rst_n;

  mtpp_in_if  in_ch ();
  mtpp_out_if out_ch ();
  mtpp_cfg_if cfg_ch ();

  median_threshold_peak_picker_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  feed_t feed_q[$];
  res_t  peaks_due[$];

  sample_t    window_s[WIN];
  frame_cnt_t frames_seen;
  int         skip_left;
  offset_t    offset_now;

  logic in_acc;
  logic cfg_acc;
  int   quiet;
  int   samples_in;
  int   mismatches;
  int   hold_left;
  int   stall_mark;
  int   cycle_count;

  int unsigned thresh_probe[10]  = '{0, 13107, 0, 13108, 0, 40000, 0, 50000, 60000, 0};
  int unsigned plateau_probe[4]  = '{5, 30000, 30000, 5};
  int unsigned low_probe[4]      = '{1, 2, 1, 0};
  int unsigned top_probe[3]      = '{0, 65535, 0};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic int idle_pct();
    return (samples_in >= CALM_FROM && samples_in < CALM_TO) ? 0 : IDLE_PCT;
  endfunction

  function automatic void push_sample(sample_t v);
    int i;
    for (i = 0; i < WIN - 1; i++) window_s[i] = window_s[i + 1];
    window_s[WIN - 1] = v;
  endfunction

  function automatic bit judge_centre();
    sample_t s[WIN];
    sample_t v;
    logic [SAMPLE_BITS:0] lim;
    int i;
    int j;
    if (skip_left > 0) begin
      skip_left--;
      return 1'b0;
    end
    s = window_s;
    for (i = 1; i < WIN; i++) begin
      v = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > v) begin
        s[j + 1] = s[j];
        j--;
      end
      s[j + 1] = v;
    end
    lim = s[2] + offset_now;
    if (window_s[1] < window_s[2] && window_s[3] < window_s[2] && {1'b0, window_s[2]} > lim) begin
      skip_left = HOLDOFF_FRAMES;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_peaks(sample_t smp, logic eos);
    index_t hits[$];
    res_t   r;
    int     i;
    if (frames_seen < MAX_FRAMES) begin
      push_sample(smp);
      frames_seen++;
      if (frames_seen >= 4 && judge_centre())
        hits.insert(hits.size(), index_t'(frames_seen - 3));
    end
    if (eos) begin
      push_sample('0);
      if (frames_seen >= 3 && judge_centre())
        hits.insert(hits.size(), index_t'(frames_seen - 2));
      for (i = 0; i < WIN; i++) window_s[i] = '0;
      frames_seen = '0;
      skip_left = 0;
    end
    foreach (hits[n]) begin
      r.peak_index  = hits[n];
      r.last_of_run = (n == hits.size() - 1);
      peaks_due.insert(peaks_due.size(), r);
    end
  endfunction

  task automatic flag_mismatch(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("peak mismatch (%s): expected index %0d last %0b, got index %0d last %0b",
               what, want.peak_index, want.last_of_run, got.peak_index, got.last_of_run);
  endtask

  task automatic add_sample(int unsigned v, bit eos);
    feed_t f;
    f.kind   = FEED_SAMPLE;
    f.sample = sample_t'(v);
    f.eos    = eos;
    f.offset = '0;
    feed_q.insert(feed_q.size(), f);
  endtask

  task automatic add_offset(int unsigned v);
    feed_t f;
    f.kind   = FEED_OFFSET;
    f.sample = '0;
    f.eos    = 1'b0;
    f.offset = offset_t'(v);
    feed_q.insert(feed_q.size(), f);
  endtask

  task automatic add_sequence(int len, shape_t shape);
    int i;
    int unsigned base;
    int unsigned v;
    base = $urandom_range(0, 4000);
    for (i = 0; i < len; i++) begin
      case (shape)
        SHAPE_NOISE: v = $urandom_range(0, 65535);
        SHAPE_SPIKY: v = ($urandom_range(0, 4) == 0) ? $urandom_range(12000, 65535)
                                                      : base + $urandom_range(0, 3000);
        default:     v = $urandom_range(0, 4) * 8000;
      endcase
      add_sample(v, i == len - 1);
    end
  endtask

  // Sender: hold the item until its transfer, then offer the next one or idle.
  always @(negedge clk) begin : feed
    logic  nv;
    logic  cv;
    feed_t f;
    nv = in_ch.valid && !in_acc;
    cv = cfg_ch.valid && !cfg_acc;
    if (rst_n && !nv && !cv && feed_q.size() > 0) begin
      if (feed_q[0].kind == FEED_OFFSET) begin
        if (peaks_due.size() == 0 && quiet >= SETTLE_CYCLES) begin
          f = feed_q.pop_front();
          cv = 1'b1;
          cfg_ch.threshold_offset <= f.offset;
        end
      end else if ($urandom_range(0, 99) >= idle_pct()) begin
        f = feed_q.pop_front();
        nv = 1'b1;
        in_ch.novelty_sample  <= f.sample;
        in_ch.end_of_sequence <= f.eos;
      end
    end
    in_ch.valid  <= nv;
    cfg_ch.valid <= cv;
  end

  // Receiver: random stalls, plus long hold-offs so the result queue fills.
  always @(negedge clk) begin : drain
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rst_n && samples_in >= stall_mark) begin
      out_ch.ready <= 1'b0;
      hold_left <= STALL_CYCLES;
      stall_mark <= (stall_mark == STALL_FIRST) ? STALL_SECOND : 32'h7fffffff;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(0, 99) >= idle_pct());
    end
  end

  always @(posedge clk) begin : observe
    res_t want;
    res_t got;
    in_acc  <= rst_n && in_ch.valid && in_ch.ready;
    cfg_acc <= rst_n && cfg_ch.valid && cfg_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.peak_index  = out_ch.peak_index;
        got.last_of_run = out_ch.last_of_run;
        if (peaks_due.size() == 0) begin
          flag_mismatch("nothing expected", '0, got);
        end else begin
          want = peaks_due.pop_front();
          if (got.peak_index !== want.peak_index || got.last_of_run !== want.last_of_run)
            flag_mismatch("wrong field", want, got);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) offset_now = cfg_ch.threshold_offset;
      if (in_ch.valid && in_ch.ready) begin
        predict_peaks(in_ch.novelty_sample, in_ch.end_of_sequence);
        samples_in <= samples_in + 1;
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int p;
    int i;
    int r;
    int target;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.novelty_sample = '0;
    in_ch.end_of_sequence = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.threshold_offset = '0;
    out_ch.ready = 1'b0;
    in_acc = 1'b0;
    cfg_acc = 1'b0;
    quiet = 0;
    samples_in = 0;
    mismatches = 0;
    hold_left = 0;
    stall_mark = STALL_FIRST;
    for (i = 0; i < WIN; i++) window_s[i] = '0;
    frames_seen = '0;
    skip_left = 0;
    offset_now = OFFSET_RESET;

    // one- and two-frame sequences
    add_sample(16'hFFFF, 1'b1);
    add_sample(16'hFFFF, 1'b0);
    add_sample(0, 1'b1);
    // equal to threshold, a peak, then hold-off skips through the flushed frame
    foreach (thresh_probe[n]) add_sample(thresh_probe[n], n == 9);
    foreach (plateau_probe[n]) add_sample(plateau_probe[n], n == 3);
    add_offset(0);
    foreach (low_probe[n]) add_sample(low_probe[n], n == 3);
    add_offset(16'hFFFF);
    foreach (top_probe[n]) add_sample(top_probe[n], n == 2);
    add_offset(OFFSET_RESET);

    for (p = 0; p < 6; p++) begin
      case (p)
        1:       add_offset(0);
        4:       add_offset(16'hFFFF);
        default: add_offset($urandom_range(0, 24000));
      endcase
      target = feed_q.size() + PHASE_ITEMS;
      while (feed_q.size() < target) begin
        r = $urandom_range(0, 99);
        if (r < 12)      add_sequence($urandom_range(1, 6), SHAPE_NOISE);
        else if (r < 70) add_sequence($urandom_range(3, 40), SHAPE_SPIKY);
        else             add_sequence($urandom_range(3, 30), SHAPE_STEPS);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() > 0 || in_ch.valid || cfg_ch.valid) @(posedge clk);
    while (peaks_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && peaks_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
